@@ rtl/core/tl_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tl_pkg
// Types, codes and character helpers shared by the token lexer.
// ----------------------------------------------------------------------------
package tl_pkg;

    typedef enum logic [3:0] {
        ST_INIT   = 4'd0,
        ST_TRUE   = 4'd1,
        ST_FALSE  = 4'd2,
        ST_LAMBDA = 4'd3,
        ST_MINUS  = 4'd4,
        ST_INT    = 4'd5,
        ST_DEC    = 4'd6,
        ST_STR    = 4'd7,
        ST_ESC    = 4'd8,
        ST_NAME   = 4'd9
    } lex_state_t;

    typedef enum logic [1:0] {
        REC_CONTENT = 2'd0,
        REC_END     = 2'd1,
        REC_ERROR   = 2'd2,
        REC_EOS     = 2'd3
    } rec_kind_t;

    localparam logic [1:0] ERR_BAD_CHAR     = 2'd0;
    localparam logic [1:0] ERR_UNTERMINATED = 2'd1;
    localparam logic [1:0] ERR_OVERFLOW     = 2'd2;

    localparam logic [4:0] CLS_PLUS   = 5'd0;
    localparam logic [4:0] CLS_MINUS  = 5'd1;
    localparam logic [4:0] CLS_STAR   = 5'd2;
    localparam logic [4:0] CLS_BAR    = 5'd3;
    localparam logic [4:0] CLS_AMP    = 5'd4;
    localparam logic [4:0] CLS_COLON  = 5'd5;
    localparam logic [4:0] CLS_COMMA  = 5'd6;
    localparam logic [4:0] CLS_LBRACK = 5'd7;
    localparam logic [4:0] CLS_RBRACK = 5'd8;
    localparam logic [4:0] CLS_LBRACE = 5'd9;
    localparam logic [4:0] CLS_RBRACE = 5'd10;
    localparam logic [4:0] CLS_LPAREN = 5'd11;
    localparam logic [4:0] CLS_RPAREN = 5'd12;
    localparam logic [4:0] CLS_BOOL   = 5'd13;
    localparam logic [4:0] CLS_LAMBDA = 5'd14;
    localparam logic [4:0] CLS_INT    = 5'd15;
    localparam logic [4:0] CLS_DEC    = 5'd16;
    localparam logic [4:0] CLS_STR    = 5'd17;
    localparam logic [4:0] CLS_NAME   = 5'd18;

    localparam logic [63:0] MAG_LIMIT = 64'h8000_0000_0000_0000;
    localparam logic [63:0] MAG_DIV10 = 64'd922337203685477580;
    localparam logic [3:0]  MAG_LAST_DIGIT = 4'd8;

    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_MINUS     = 8'h2D;
    localparam logic [7:0] CH_DOT       = 8'h2E;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;

    typedef struct packed {
        rec_kind_t          kind;
        logic [7:0]         content_byte;
        logic [4:0]         token_class;
        logic               bool_value;
        logic signed [63:0] int_value;
        logic [1:0]         error_code;
        logic               last_of_run;
    } record_t;

    typedef struct packed {
        record_t [2:0] recs;
        logic [1:0]    count;
    } rec_load_t;

    typedef struct packed {
        lex_state_t  lex_state;
        logic [2:0]  kw_pos;
        logic [63:0] int_mag;
        logic        neg;
        logic        ovf;
        logic        err_hold;
    } lex_ctx_t;

    typedef struct packed {
        logic       hit;
        logic [4:0] cls;
    } punct_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"))
            || (c == CH_UNDERSCORE);
    endfunction

    function automatic logic is_name_char(input logic [7:0] c);
        return is_alpha(c) || is_digit(c);
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
    endfunction

    function automatic punct_t punct_class(input logic [7:0] c);
        punct_t p;
        p.hit = 1'b1;
        p.cls = CLS_PLUS;
        case (c)
            "+":     p.cls = CLS_PLUS;
            "-":     p.cls = CLS_MINUS;
            "*":     p.cls = CLS_STAR;
            "|":     p.cls = CLS_BAR;
            "&":     p.cls = CLS_AMP;
            ":":     p.cls = CLS_COLON;
            ",":     p.cls = CLS_COMMA;
            "[":     p.cls = CLS_LBRACK;
            "]":     p.cls = CLS_RBRACK;
            "{":     p.cls = CLS_LBRACE;
            "}":     p.cls = CLS_RBRACE;
            "(":     p.cls = CLS_LPAREN;
            ")":     p.cls = CLS_RPAREN;
            default: p.hit = 1'b0;
        endcase
        return p;
    endfunction

    function automatic logic [2:0] kw_len(input lex_state_t s);
        logic [2:0] n;
        case (s)
            ST_TRUE:   n = 3'd4;
            ST_FALSE:  n = 3'd5;
            ST_LAMBDA: n = 3'd6;
            default:   n = 3'd0;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] kw_char(input lex_state_t s, input logic [2:0] pos);
        logic [7:0] c;
        c = 8'd0;
        case (s)
            ST_TRUE:
            begin
                case (pos)
                    3'd0:    c = "t";
                    3'd1:    c = "r";
                    3'd2:    c = "u";
                    3'd3:    c = "e";
                    default: c = 8'd0;
                endcase
            end
            ST_FALSE:
            begin
                case (pos)
                    3'd0:    c = "f";
                    3'd1:    c = "a";
                    3'd2:    c = "l";
                    3'd3:    c = "s";
                    3'd4:    c = "e";
                    default: c = 8'd0;
                endcase
            end
            ST_LAMBDA:
            begin
                case (pos)
                    3'd0:    c = "l";
                    3'd1:    c = "a";
                    3'd2:    c = "m";
                    3'd3:    c = "b";
                    3'd4:    c = "d";
                    3'd5:    c = "a";
                    default: c = 8'd0;
                endcase
            end
            default: c = 8'd0;
        endcase
        return c;
    endfunction

endpackage

@@ rtl/core/tl_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tl_in_if
// Character request channel: one byte or an end-of-input mark per request.
// ----------------------------------------------------------------------------
interface tl_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_input;

    modport source (output valid, output in_byte, output end_of_input, input ready);
    modport sink (input valid, input in_byte, input end_of_input, output ready);
endinterface

@@ rtl/core/tl_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tl_out_if
// Record request channel: content bytes, token ends, errors, end of stream.
// ----------------------------------------------------------------------------
interface tl_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         record_kind;
    logic [7:0]         content_byte;
    logic [4:0]         token_class;
    logic               bool_value;
    logic signed [63:0] int_value;
    logic [1:0]         error_code;
    logic               last_of_run;

    modport source (
        output valid, output record_kind, output content_byte, output token_class,
        output bool_value, output int_value, output error_code, output last_of_run,
        input ready
    );
    modport sink (
        input valid, input record_kind, input content_byte, input token_class,
        input bool_value, input int_value, input error_code, input last_of_run,
        output ready
    );
endinterface

@@ rtl/core/tl_step.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tl_step
// One lexer transition: current context and a byte give the next context
// and up to three records.
// ----------------------------------------------------------------------------
module tl_step (
    input  tl_pkg::lex_ctx_t  cur,
    input  logic [7:0]        in_byte,
    input  logic              end_of_input,
    output tl_pkg::lex_ctx_t  nxt,
    output tl_pkg::rec_load_t load
);
    import tl_pkg::*;

    lex_ctx_t    clr_ctx;
    logic [63:0] mag_x10;
    logic [63:0] digit_ext;
    logic        acc_over;

    record_t     fin_rec;
    logic        fin_emit;
    logic        fin_err;

    logic        ext_ok;
    logic        ext_emit;
    record_t     ext_rec;
    lex_ctx_t    ext_ctx;

    logic [1:0]  st_n;
    record_t     st_rec0;
    record_t     st_rec1;
    lex_ctx_t    st_ctx;
    punct_t      pc;
    record_t     content_rec;

    always_comb
    begin
        clr_ctx = '0;
        clr_ctx.err_hold = cur.err_hold;
    end

    // magnitude times ten plus the digit
    assign mag_x10   = (cur.int_mag << 3) + (cur.int_mag << 1);
    assign digit_ext = {60'd0, in_byte[3:0]};
    assign acc_over  = (cur.int_mag > MAG_DIV10)
                    || ((cur.int_mag == MAG_DIV10) && (in_byte[3:0] > MAG_LAST_DIGIT));
    assign pc = punct_class(in_byte);

    always_comb
    begin
        content_rec = '0;
        content_rec.kind = REC_CONTENT;
        content_rec.content_byte = in_byte;
    end

    // close the open token
    always_comb
    begin
        fin_rec = '0;
        fin_emit = 1'b0;
        fin_err = 1'b0;
        case (cur.lex_state)
            ST_TRUE, ST_FALSE, ST_LAMBDA:
            begin
                fin_emit = 1'b1;
                fin_rec.kind = REC_END;
                if (cur.kw_pos == kw_len(cur.lex_state))
                begin
                    if (cur.lex_state == ST_LAMBDA)
                    begin
                        fin_rec.token_class = CLS_LAMBDA;
                    end
                    else
                    begin
                        fin_rec.token_class = CLS_BOOL;
                        fin_rec.bool_value = (cur.lex_state == ST_TRUE);
                    end
                end
                else
                begin
                    fin_rec.token_class = CLS_NAME;
                end
            end
            ST_MINUS:
            begin
                fin_emit = 1'b1;
                fin_rec.kind = REC_END;
                fin_rec.token_class = CLS_MINUS;
            end
            ST_INT:
            begin
                fin_emit = 1'b1;
                if (cur.ovf || (!cur.neg && (cur.int_mag >= MAG_LIMIT)))
                begin
                    fin_err = 1'b1;
                    fin_rec.kind = REC_ERROR;
                    fin_rec.error_code = ERR_OVERFLOW;
                end
                else
                begin
                    fin_rec.kind = REC_END;
                    fin_rec.token_class = CLS_INT;
                    fin_rec.int_value = cur.neg ? $signed(64'd0 - cur.int_mag)
                                                : $signed(cur.int_mag);
                end
            end
            ST_DEC:
            begin
                fin_emit = 1'b1;
                fin_rec.kind = REC_END;
                fin_rec.token_class = CLS_DEC;
            end
            ST_STR, ST_ESC:
            begin
                fin_emit = 1'b1;
                fin_err = 1'b1;
                fin_rec.kind = REC_ERROR;
                fin_rec.error_code = ERR_UNTERMINATED;
            end
            ST_NAME:
            begin
                fin_emit = 1'b1;
                fin_rec.kind = REC_END;
                fin_rec.token_class = CLS_NAME;
            end
            default:
            begin
                fin_emit = 1'b0;
            end
        endcase
    end

    // extend the open token
    always_comb
    begin
        ext_ok = 1'b0;
        ext_emit = 1'b0;
        ext_rec = content_rec;
        ext_ctx = cur;
        case (cur.lex_state)
            ST_TRUE, ST_FALSE, ST_LAMBDA:
            begin
                if ((cur.kw_pos < kw_len(cur.lex_state))
                    && (in_byte == kw_char(cur.lex_state, cur.kw_pos)))
                begin
                    ext_ok = 1'b1;
                    ext_ctx.kw_pos = cur.kw_pos + 3'd1;
                end
                else if (is_name_char(in_byte))
                begin
                    ext_ok = 1'b1;
                    ext_ctx.lex_state = ST_NAME;
                end
                ext_emit = ext_ok;
            end
            ST_MINUS, ST_INT:
            begin
                if (is_digit(in_byte))
                begin
                    ext_ok = 1'b1;
                    ext_ctx.lex_state = ST_INT;
                    if (!cur.ovf)
                    begin
                        if (acc_over)
                        begin
                            ext_ctx.ovf = 1'b1;
                        end
                        else
                        begin
                            ext_ctx.int_mag = mag_x10 + digit_ext;
                        end
                    end
                end
                else if ((in_byte == CH_DOT) && (cur.lex_state == ST_INT))
                begin
                    ext_ok = 1'b1;
                    ext_ctx.lex_state = ST_DEC;
                end
                ext_emit = ext_ok;
            end
            ST_DEC:
            begin
                ext_ok = is_digit(in_byte);
                ext_emit = ext_ok;
            end
            ST_STR:
            begin
                ext_ok = 1'b1;
                if (in_byte == CH_BACKSLASH)
                begin
                    ext_ctx.lex_state = ST_ESC;
                end
                else if (in_byte == CH_QUOTE)
                begin
                    ext_emit = 1'b1;
                    ext_rec = '0;
                    ext_rec.kind = REC_END;
                    ext_rec.token_class = CLS_STR;
                    ext_ctx = clr_ctx;
                end
                else
                begin
                    ext_emit = 1'b1;
                end
            end
            ST_ESC:
            begin
                ext_ok = 1'b1;
                ext_emit = 1'b1;
                ext_ctx.lex_state = ST_STR;
            end
            ST_NAME:
            begin
                ext_ok = is_name_char(in_byte);
                ext_emit = ext_ok;
            end
            default:
            begin
                ext_ok = 1'b0;
            end
        endcase
    end

    // start a token from a cleared context
    always_comb
    begin
        st_n = 2'd0;
        st_rec0 = content_rec;
        st_rec1 = '0;
        st_ctx = clr_ctx;
        if (is_space(in_byte))
        begin
            st_n = 2'd0;
        end
        else if ((in_byte == "t") || (in_byte == "f") || (in_byte == "l"))
        begin
            st_n = 2'd1;
            st_ctx.kw_pos = 3'd1;
            if (in_byte == "t")
            begin
                st_ctx.lex_state = ST_TRUE;
            end
            else if (in_byte == "f")
            begin
                st_ctx.lex_state = ST_FALSE;
            end
            else
            begin
                st_ctx.lex_state = ST_LAMBDA;
            end
        end
        else if (in_byte == CH_MINUS)
        begin
            st_n = 2'd1;
            st_ctx.lex_state = ST_MINUS;
            st_ctx.neg = 1'b1;
        end
        else if (is_digit(in_byte))
        begin
            st_n = 2'd1;
            st_ctx.lex_state = ST_INT;
            st_ctx.int_mag = digit_ext;
        end
        else if (in_byte == CH_QUOTE)
        begin
            st_n = 2'd0;
            st_ctx.lex_state = ST_STR;
        end
        else if (is_alpha(in_byte))
        begin
            st_n = 2'd1;
            st_ctx.lex_state = ST_NAME;
        end
        else if (pc.hit)
        begin
            st_n = 2'd2;
            st_rec1.kind = REC_END;
            st_rec1.token_class = pc.cls;
        end
        else
        begin
            st_n = 2'd1;
            st_rec0 = '0;
            st_rec0.kind = REC_ERROR;
            st_rec0.error_code = ERR_BAD_CHAR;
            st_ctx.err_hold = 1'b1;
        end
    end

    always_comb
    begin
        nxt = cur;
        load = '0;
        if (end_of_input)
        begin
            nxt = '0;
            if (!cur.err_hold && fin_emit)
            begin
                load.recs[0] = fin_rec;
                load.recs[1] = '0;
                load.recs[1].kind = REC_EOS;
                load.count = 2'd2;
            end
            else
            begin
                load.recs[0] = '0;
                load.recs[0].kind = REC_EOS;
                load.count = 2'd1;
            end
        end
        else if (!cur.err_hold)
        begin
            if (cur.lex_state == ST_INIT)
            begin
                nxt = st_ctx;
                load.recs[0] = st_rec0;
                load.recs[1] = st_rec1;
                load.count = st_n;
            end
            else if (ext_ok)
            begin
                nxt = ext_ctx;
                load.recs[0] = ext_rec;
                load.count = {1'b0, ext_emit};
            end
            else if (fin_err)
            begin
                nxt = clr_ctx;
                nxt.err_hold = 1'b1;
                load.recs[0] = fin_rec;
                load.count = 2'd1;
            end
            else
            begin
                nxt = st_ctx;
                load.recs[0] = fin_rec;
                load.recs[1] = st_rec0;
                load.recs[2] = st_rec1;
                load.count = st_n + 2'd1;
            end
        end
        case (load.count)
            2'd1:    load.recs[0].last_of_run = 1'b1;
            2'd2:    load.recs[1].last_of_run = 1'b1;
            2'd3:    load.recs[2].last_of_run = 1'b1;
            default: load.recs[0].last_of_run = 1'b0;
        endcase
    end

endmodule

@@ rtl/core/tl_rec_buf.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tl_rec_buf
// Result register for the records of one byte, handed out one per cycle while out_ready holds.
// ----------------------------------------------------------------------------
module tl_rec_buf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load_en,
    input  tl_pkg::rec_load_t load,
    input  logic              out_ready,
    output logic              can_load,
    output logic              out_valid,
    output tl_pkg::record_t   out_rec
);
    import tl_pkg::*;

    record_t    slot_reg [3];
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic [1:0] head_reg;
    logic [1:0] head_next;
    logic       fire;

    assign out_valid = (count_reg != 2'd0);
    assign out_rec   = slot_reg[head_reg];
    assign fire      = out_valid && out_ready;
    assign can_load  = (count_reg == 2'd0) || ((count_reg == 2'd1) && out_ready);

    always_comb
    begin
        count_next = count_reg;
        head_next = head_reg;
        if (load_en)
        begin
            count_next = load.count;
            head_next = 2'd0;
        end
        else if (fire)
        begin
            count_next = count_reg - 2'd1;
            head_next = head_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
            head_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            head_reg <= head_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            slot_reg[0] <= load.recs[0];
            slot_reg[1] <= load.recs[1];
            slot_reg[2] <= load.recs[2];
        end
    end

endmodule

@@ rtl/core/token_lexer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// token_lexer
// Byte-serial tokenizer: streams token text and closes each token with a
// class, bool and integer value record; flags errors.
// ----------------------------------------------------------------------------
//  channel   dir  contents
//  in_ch     in   in_byte, end_of_input
//  out_ch    out  record_kind, content_byte, token_class, bool_value,
//                 int_value, error_code, last_of_run
//
//  one byte per cycle while out_ch is ready and each byte gives at most one
//  record; a byte giving more records holds the input while the single
//  record output port hands them out
//  path: input register, then the transition into the result register
//  rst_n clears lexer context and the valid state of both registers, no clearing pass
//  out_ch stalls back up through the result register into in_ch.ready
module token_lexer (
    input  logic     clk,
    input  logic     rst_n,
    tl_in_if.sink    in_ch,
    tl_out_if.source out_ch
);
    import tl_pkg::*;

    logic       stg_valid_reg;
    logic       stg_valid_next;
    logic [7:0] stg_byte_reg;
    logic       stg_eoi_reg;
    lex_ctx_t   ctx_reg;
    lex_ctx_t   ctx_next;
    lex_ctx_t   step_ctx;
    rec_load_t  step_load;
    logic       can_load;
    logic       advance;
    logic       in_fire;
    record_t    out_rec;

    assign advance     = stg_valid_reg && can_load;
    assign in_ch.ready = !stg_valid_reg || advance;
    assign in_fire     = in_ch.valid && in_ch.ready;

    tl_step u_step (
        .cur          (ctx_reg),
        .in_byte      (stg_byte_reg),
        .end_of_input (stg_eoi_reg),
        .nxt          (step_ctx),
        .load         (step_load)
    );

    tl_rec_buf u_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .load_en   (advance),
        .load      (step_load),
        .out_ready (out_ch.ready),
        .can_load  (can_load),
        .out_valid (out_ch.valid),
        .out_rec   (out_rec)
    );

    assign out_ch.record_kind  = out_rec.kind;
    assign out_ch.content_byte = out_rec.content_byte;
    assign out_ch.token_class  = out_rec.token_class;
    assign out_ch.bool_value   = out_rec.bool_value;
    assign out_ch.int_value    = out_rec.int_value;
    assign out_ch.error_code   = out_rec.error_code;
    assign out_ch.last_of_run  = out_rec.last_of_run;

    always_comb
    begin
        stg_valid_next = stg_valid_reg;
        ctx_next = ctx_reg;
        if (advance)
        begin
            ctx_next = step_ctx;
            stg_valid_next = 1'b0;
        end
        if (in_fire)
        begin
            stg_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= 1'b0;
            ctx_reg <= '0;
        end
        else
        begin
            stg_valid_reg <= stg_valid_next;
            ctx_reg <= ctx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            stg_byte_reg <= in_ch.in_byte;
            stg_eoi_reg <= in_ch.end_of_input;
        end
    end

`ifndef SYNTHESIS
    // held error leaves no token open
    a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ctx_reg.err_hold |-> (ctx_reg.lex_state == ST_INIT))
        else $error("token open while error held");

    // end of input returns the context to reset
    a_eoi_reset: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && stg_eoi_reg) |=> ((ctx_reg.lex_state == ST_INIT) && !ctx_reg.err_hold
            && (ctx_reg.int_mag == 64'd0) && !ctx_reg.neg && !ctx_reg.ovf))
        else $error("context not cleared after end of input");

    // overflow only inside a numeric token
    a_ovf_state: assert property (@(posedge clk) disable iff (!rst_n)
        ctx_reg.ovf |-> ((ctx_reg.lex_state == ST_INT) || (ctx_reg.lex_state == ST_DEC)))
        else $error("overflow flag outside number");

    // keyword position stays within the longest keyword
    a_kw_pos: assert property (@(posedge clk) disable iff (!rst_n)
        ctx_reg.kw_pos <= 3'd6)
        else $error("keyword position out of range");

    // staged request waits while the result register still holds records
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (stg_valid_reg && !can_load) |=> stg_valid_reg)
        else $error("staged request lost while stalled");
`endif

endmodule

@@ tb/tb_lexer_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lexer_pkg
// Scoreboard for the token lexer. It keeps its own lexer state, turns
// every accepted character request into the records it should cause, and
// checks each record leaving the block against the oldest one waiting.
// ----------------------------------------------------------------------------
package tb_lexer_pkg;

    import tl_pkg::*;

    class record_scoreboard;

        lex_state_t  st;
        logic [2:0]  kw_pos;
        logic [63:0] mag;
        logic        neg;
        logic        ovf;
        logic        hold;
        string       kw_text [3];
        record_t     run_q [$];
        record_t     pending_records [$];
        int unsigned errors;

        function new();
            kw_text = '{"true", "false", "lambda"};
            errors = 0;
            clear_all();
        endfunction

        function void clear_token();
            st = ST_INIT;
            kw_pos = '0;
            mag = '0;
            neg = 1'b0;
            ovf = 1'b0;
        endfunction

        function void clear_all();
            clear_token();
            hold = 1'b0;
        endfunction

        function int pending();
            return pending_records.size();
        endfunction

        function void emit(rec_kind_t kind, logic [7:0] data, logic [4:0] cls, logic bv,
                           logic [63:0] iv, logic [1:0] err);
            record_t r;
            r.kind = kind;
            r.content_byte = data;
            r.token_class = cls;
            r.bool_value = bv;
            r.int_value = iv;
            r.error_code = err;
            r.last_of_run = 1'b0;
            run_q.insert(run_q.size(), r);
        endfunction

        function void put_content(logic [7:0] c);
            emit(REC_CONTENT, c, '0, 1'b0, '0, '0);
        endfunction

        function void end_token(logic [4:0] cls);
            emit(REC_END, '0, cls, 1'b0, '0, '0);
        endfunction

        function void raise_error(logic [1:0] err);
            emit(REC_ERROR, '0, '0, 1'b0, '0, err);
            hold = 1'b1;
        endfunction

        function bit digit(logic [7:0] c);
            return c >= "0" && c <= "9";
        endfunction

        function bit alpha(logic [7:0] c);
            return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CH_UNDERSCORE;
        endfunction

        function bit name_char(logic [7:0] c);
            return alpha(c) || digit(c);
        endfunction

        // position in this list is the token class
        function bit punct_code(input logic [7:0] c, output logic [4:0] cls);
            string marks;
            marks = "+-*|&:,[]{}()";
            cls = '0;
            for (int i = 0; i < marks.len(); i++)
            begin
                if (marks[i] == c)
                begin
                    cls = 5'(i);
                    return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        function void add_digit(logic [7:0] c);
            logic [63:0] d;
            d = {56'd0, c - 8'h30};
            if (!ovf)
            begin
                if (mag > MAG_DIV10 || (mag == MAG_DIV10 && d > {60'd0, MAG_LAST_DIGIT}))
                    ovf = 1'b1;
                else
                    mag = mag * 64'd10 + d;
            end
        endfunction

        function void close_token();
            int k;
            case (st)
                ST_TRUE, ST_FALSE, ST_LAMBDA:
                begin
                    k = int'(st) - int'(ST_TRUE);
                    if (kw_pos == kw_text[k].len())
                    begin
                        if (st == ST_LAMBDA)
                            end_token(CLS_LAMBDA);
                        else
                            emit(REC_END, '0, CLS_BOOL, st == ST_TRUE, '0, '0);
                    end
                    else
                        end_token(CLS_NAME);
                end
                ST_MINUS: end_token(CLS_MINUS);
                ST_INT:
                begin
                    if (ovf || (!neg && mag >= MAG_LIMIT))
                        raise_error(ERR_OVERFLOW);
                    else
                        emit(REC_END, '0, CLS_INT, 1'b0, neg ? 64'd0 - mag : mag, '0);
                end
                ST_DEC: end_token(CLS_DEC);
                ST_STR, ST_ESC: raise_error(ERR_UNTERMINATED);
                ST_NAME: end_token(CLS_NAME);
                default: ;
            endcase
            clear_token();
        endfunction

        function bit grow_token(logic [7:0] c);
            int k;
            case (st)
                ST_TRUE, ST_FALSE, ST_LAMBDA:
                begin
                    k = int'(st) - int'(ST_TRUE);
                    if (kw_pos < kw_text[k].len() && c == kw_text[k][kw_pos])
                        kw_pos++;
                    else if (name_char(c))
                        st = ST_NAME;
                    else
                        return 1'b0;
                    put_content(c);
                    return 1'b1;
                end
                ST_MINUS, ST_INT:
                begin
                    if (digit(c))
                    begin
                        st = ST_INT;
                        add_digit(c);
                    end
                    else if (c == CH_DOT && st == ST_INT)
                        st = ST_DEC;
                    else
                        return 1'b0;
                    put_content(c);
                    return 1'b1;
                end
                ST_DEC:
                begin
                    if (!digit(c))
                        return 1'b0;
                    put_content(c);
                    return 1'b1;
                end
                ST_STR:
                begin
                    if (c == CH_BACKSLASH)
                        st = ST_ESC;
                    else if (c == CH_QUOTE)
                    begin
                        end_token(CLS_STR);
                        clear_token();
                    end
                    else
                        put_content(c);
                    return 1'b1;
                end
                ST_ESC:
                begin
                    put_content(c);
                    st = ST_STR;
                    return 1'b1;
                end
                ST_NAME:
                begin
                    if (!name_char(c))
                        return 1'b0;
                    put_content(c);
                    return 1'b1;
                end
                default: return 1'b0;
            endcase
        endfunction

        function void open_token(logic [7:0] c);
            logic [4:0] cls;
            if (c == " " || (c >= 8'd9 && c <= 8'd13))
                return;
            if (c == "t" || c == "f" || c == "l")
            begin
                st = (c == "t") ? ST_TRUE : ((c == "f") ? ST_FALSE : ST_LAMBDA);
                kw_pos = 3'd1;
                put_content(c);
            end
            else if (c == CH_MINUS)
            begin
                st = ST_MINUS;
                neg = 1'b1;
                put_content(c);
            end
            else if (digit(c))
            begin
                st = ST_INT;
                add_digit(c);
                put_content(c);
            end
            else if (c == CH_QUOTE)
                st = ST_STR;
            else if (alpha(c))
            begin
                st = ST_NAME;
                put_content(c);
            end
            else if (punct_code(c, cls))
            begin
                put_content(c);
                end_token(cls);
            end
            else
                raise_error(ERR_BAD_CHAR);
        endfunction

        function void note_request(logic [7:0] c, logic eoi);
            record_t r;
            run_q.delete();
            if (eoi)
            begin
                if (!hold)
                    close_token();
                emit(REC_EOS, '0, '0, 1'b0, '0, '0);
                clear_all();
            end
            else if (!hold)
            begin
                if (st == ST_INIT)
                    open_token(c);
                else if (!grow_token(c))
                begin
                    close_token();
                    if (!hold)
                        open_token(c);
                end
            end
            if (run_q.size() > 0)
            begin
                r = run_q[run_q.size() - 1];
                r.last_of_run = 1'b1;
                run_q[run_q.size() - 1] = r;
            end
            pending_records = {pending_records, run_q};
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            errors++;
        endtask

        task cmp(string field, logic [63:0] got, logic [63:0] want);
            if (got !== want)
                report($sformatf("%s got %0h want %0h", field, got, want));
        endtask

        task check_record(record_t got);
            record_t want;
            if (pending_records.size() == 0)
                report($sformatf("record kind %0d with nothing pending", got.kind));
            else
            begin
                want = pending_records.pop_front();
                cmp("record_kind", 64'(got.kind), 64'(want.kind));
                cmp("content_byte", 64'(got.content_byte), 64'(want.content_byte));
                cmp("token_class", 64'(got.token_class), 64'(want.token_class));
                cmp("bool_value", 64'(got.bool_value), 64'(want.bool_value));
                cmp("int_value", got.int_value, want.int_value);
                cmp("error_code", 64'(got.error_code), 64'(want.error_code));
                cmp("last_of_run", 64'(got.last_of_run), 64'(want.last_of_run));
            end
        endtask

    endclass

endpackage

@@ tb/tb_token_lexer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_token_lexer
// Drives character streams into the token lexer: a few hand-written
// streams for keyword edges, lone minus, escapes, bad characters and
// unterminated strings, then random streams of mostly well-formed tokens
// with noise. Both channels idle at random; every record is checked.
// ----------------------------------------------------------------------------
module tb_token_lexer;

    import tl_pkg::*;
    import tb_lexer_pkg::*;

    localparam int ITEM_TARGET = 410;
    localparam int CYCLE_LIMIT = 200000;
    localparam int TAIL_CYCLES = 10;

    logic             clk;
    logic             rst_n;
    int unsigned      cycles = 0;
    int unsigned      sent = 0;
    bit               calm = 1'b0;
    logic [7:0]       text_q [$];
    string            name_set =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz_0123456789";
    record_scoreboard board;

    tl_in_if  in_ch ();
    tl_out_if out_ch ();

    token_lexer dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic bit take_break();
        return !calm && ($urandom_range(99) < 6);
    endfunction

    function automatic void add_char(logic [7:0] c);
        text_q.insert(text_q.size(), c);
    endfunction

    function automatic void put_str(string s);
        for (int i = 0; i < s.len(); i++)
            add_char(s[i]);
    endfunction

    function automatic void put_name_chars(int lo, int hi);
        int n;
        n = $urandom_range(lo, hi);
        for (int i = 0; i < n; i++)
            add_char(name_set[$urandom_range(name_set.len() - 1)]);
    endfunction

    function automatic void put_digits(int lo, int hi);
        int n;
        n = $urandom_range(lo, hi);
        for (int i = 0; i < n; i++)
            add_char(8'h30 + 8'($urandom_range(9)));
    endfunction

    function automatic void put_token();
        string      punct_marks;
        string      keywords [3];
        string      extremes [5];
        string      kw;
        int         pick;
        int         n;
        logic [7:0] c;
        punct_marks = "+-*|&:,[]{}()";
        keywords = '{"true", "false", "lambda"};
        extremes = '{"9223372036854775807", "-9223372036854775808",
                     "9223372036854775808", "-9223372036854775809",
                     "123456789012345678901234"};
        kw = keywords[$urandom_range(2)];
        pick = $urandom_range(99);
        if (pick < 12)
            add_char(punct_marks[$urandom_range(12)]);
        else if (pick < 24)
            put_str(kw);
        else if (pick < 32)
        begin
            // keyword prefix, or keyword or prefix followed by more name characters
            n = $urandom_range(1, kw.len());
            for (int i = 0; i < n; i++)
                add_char(kw[i]);
            if (n == kw.len() || $urandom_range(1))
                put_name_chars(1, 2);
        end
        else if (pick < 44)
        begin
            add_char(name_set[$urandom_range(52)]);
            put_name_chars(0, 5);
        end
        else if (pick < 60)
        begin
            if ($urandom_range(1))
                add_char(CH_MINUS);
            put_digits(1, 6);
        end
        else if (pick < 64)
            put_str(extremes[$urandom_range(4)]);
        else if (pick < 72)
        begin
            if ($urandom_range(3) == 0)
                add_char(CH_MINUS);
            put_digits(1, 3);
            add_char(CH_DOT);
            put_digits(0, 3);
        end
        else if (pick < 88)
        begin
            add_char(CH_QUOTE);
            n = $urandom_range(0, 6);
            for (int i = 0; i < n; i++)
            begin
                c = 8'($urandom_range(255));
                if (c == CH_QUOTE || c == CH_BACKSLASH || $urandom_range(4) == 0)
                    add_char(CH_BACKSLASH);
                add_char(c);
            end
            add_char(CH_QUOTE);
        end
        else if (pick < 93)
            add_char(CH_MINUS);
        else
            add_char(8'($urandom_range(255)));
    endfunction

    task automatic send_char(input logic [7:0] c, input logic eoi);
        while (take_break())
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.in_byte <= c;
        in_ch.end_of_input <= eoi;
        @(posedge clk);
        while (in_ch.ready !== 1'b1)
            @(posedge clk);
        board.note_request(c, eoi);
        sent++;
    endtask

    task automatic flush_text();
        foreach (text_q[i])
            send_char(text_q[i], 1'b0);
        text_q.delete();
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    // record sink
    initial
    begin
        record_t got;
        out_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
            begin
                got.kind = rec_kind_t'(out_ch.record_kind);
                got.content_byte = out_ch.content_byte;
                got.token_class = out_ch.token_class;
                got.bool_value = out_ch.bool_value;
                got.int_value = out_ch.int_value;
                got.error_code = out_ch.error_code;
                got.last_of_run = out_ch.last_of_run;
                board.check_record(got);
            end
            out_ch.ready <= !take_break();
        end
    end

    initial
    begin
        int streams;
        int n_tokens;
        int pick;
        board = new();
        rst_n <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.in_byte <= 8'h00;
        in_ch.end_of_input <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // keyword extension and prefix, lone minus, decimal, escaped quote left open
        put_str("truex lam - 7.5 \"q\\\"");
        flush_text();
        send_char(8'hA5, 1'b1);
        // bool end then a bad character, later bytes dropped
        put_str("false");
        add_char(8'h01);
        add_char(8'hFF);
        add_char(8'h00);
        flush_text();
        send_char(8'h5A, 1'b1);

        streams = 0;
        while (sent < ITEM_TARGET)
        begin
            calm = (streams >= 6 && streams < 14);
            n_tokens = $urandom_range(1, 8);
            for (int t = 0; t < n_tokens; t++)
            begin
                put_token();
                pick = $urandom_range(9);
                if (pick >= 7)
                    add_char(8'($urandom_range(9, 13)));
                else if (pick >= 4)
                    add_char(" ");
            end
            if ($urandom_range(7) == 0)
            begin
                add_char(CH_QUOTE);
                put_name_chars(0, 3);
            end
            flush_text();
            send_char(8'($urandom_range(255)), 1'b1);
            if (streams == 3)
                drain();
            streams++;
        end
        calm = 1'b0;

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (board.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/tl_pkg.sv
rtl/core/tl_in_if.sv
rtl/core/tl_out_if.sv
rtl/core/tl_step.sv
rtl/core/tl_rec_buf.sv
rtl/core/token_lexer.sv
tb/tb_lexer_pkg.sv
tb/tb_token_lexer.sv
